// ----- src/bdpc_pkg.sv -----
package bdpc_pkg;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NOW_W       = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_MS   = 2'd0,
        REG_LONG_PRESS_MS = 2'd1
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_MS_RST = 16'd500;

endpackage

// ----- src/button_debounce_press_classifier_core.sv -----
// Channel | Ports                                        | Direction
// --------+----------------------------------------------+----------
// s_      | s_valid s_ready s_pin_level s_now_ms         | in
// m_      | m_valid m_ready m_press_event m_holding_long |
//         | m_stable_pressed                             | out
// cfg     | cfg_wr_en cfg_index cfg_wdata                | in
//
// One request per cycle sustained while m_ready holds; each result passes the input register, then the result register.
// The state update is a single pass from the input register to the result register.
// aresetn (sync, active low) clears control and state; thresholds return to 50 and 500 ms.
// A stalled result holds the update stage; the input register then fills and drops s_ready.
module button_debounce_press_classifier_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_pin_level,
    input  logic [bdpc_pkg::NOW_W-1:0]            s_now_ms,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [1:0]                            m_press_event,
    output logic                                  m_holding_long,
    output logic                                  m_stable_pressed,
    input  logic                                  cfg_wr_en,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import bdpc_pkg::*;

    typedef logic [TIME_WIDTH-1:0] time_t;

    // config
    logic [CFG_DATA_W-1:0] debounce_ms_reg;
    logic [CFG_DATA_W-1:0] long_press_ms_reg;

    // input stage
    logic  in_valid_reg;
    logic  in_pin_reg;
    time_t in_now_reg;

    // block state
    logic  prev_raw_pressed_reg;
    time_t debounce_stamp_reg;
    logic  debounced_state_reg;
    time_t press_stamp_reg;
    logic  long_reported_reg;
    logic  long_active_reg;

    // result stage
    logic         out_valid_reg;
    press_event_t out_event_reg;
    logic         out_holding_reg;
    logic         out_stable_reg;

    logic advance;
    logic do_step;

    assign advance = !out_valid_reg || m_ready;
    assign do_step = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // step logic
    logic         pressed;
    time_t        stamp_eff;
    time_t        db_elapsed;
    time_t        press_elapsed;
    time_t        debounce_thr;
    time_t        long_thr;
    logic         db_ok;
    logic         db_change;
    logic         release_now;
    logic         press_now;
    logic         state_eff;
    logic         long_rep_eff;
    logic         short_ev;
    logic         long_ev;
    logic         long_reported_next;
    logic         long_active_next;
    time_t        press_stamp_next;
    press_event_t event_next;

    always_comb begin
        pressed      = !in_pin_reg;
        debounce_thr = TIME_WIDTH'(debounce_ms_reg);
        long_thr     = TIME_WIDTH'(long_press_ms_reg);
        stamp_eff    = (pressed != prev_raw_pressed_reg) ? in_now_reg : debounce_stamp_reg;
        db_elapsed   = in_now_reg - stamp_eff;
        db_ok        = db_elapsed > debounce_thr;
        db_change    = db_ok && (pressed != debounced_state_reg);
        release_now  = db_change && !pressed;
        press_now    = db_change && pressed;
        state_eff    = db_change ? pressed : debounced_state_reg;
        // a fresh press restarts the hold timer at this sample
        press_elapsed    = press_now ? '0 : (in_now_reg - press_stamp_reg);
        press_stamp_next = press_now ? in_now_reg : press_stamp_reg;
        long_rep_eff     = press_now ? 1'b0 : long_reported_reg;
        short_ev     = release_now && !long_reported_reg && (press_elapsed < long_thr);
        long_ev      = db_ok && !release_now && state_eff && !long_rep_eff
                       && (press_elapsed >= long_thr);
        long_reported_next = long_ev | long_rep_eff;
        long_active_next   = long_ev | (long_active_reg & !db_change);
        if (long_ev) begin
            event_next = EV_LONG;
        end else if (short_ev) begin
            event_next = EV_SHORT;
        end else begin
            event_next = EV_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg      <= DEBOUNCE_MS_RST;
            long_press_ms_reg    <= LONG_PRESS_MS_RST;
            in_valid_reg         <= 1'b0;
            prev_raw_pressed_reg <= 1'b0;
            debounce_stamp_reg   <= '0;
            debounced_state_reg  <= 1'b0;
            press_stamp_reg      <= '0;
            long_reported_reg    <= 1'b0;
            long_active_reg      <= 1'b0;
            out_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_wdata;
                    REG_LONG_PRESS_MS: long_press_ms_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (do_step) begin
                prev_raw_pressed_reg <= pressed;
                debounce_stamp_reg   <= stamp_eff;
                debounced_state_reg  <= state_eff;
                press_stamp_reg      <= press_stamp_next;
                long_reported_reg    <= long_reported_next;
                long_active_reg      <= long_active_next;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_pin_reg <= s_pin_level;
            in_now_reg <= TIME_WIDTH'(s_now_ms);
        end
        if (do_step) begin
            out_event_reg   <= event_next;
            out_holding_reg <= long_active_next;
            out_stable_reg  <= state_eff;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_press_event    = out_event_reg;
    assign m_holding_long   = out_holding_reg;
    assign m_stable_pressed = out_stable_reg;

    a_long_implies_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_event_reg == EV_LONG |-> out_holding_reg && out_stable_reg)
        else $error("long press reported without held state");

    a_short_implies_released: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_event_reg == EV_SHORT |-> !out_holding_reg && !out_stable_reg)
        else $error("short press reported while still pressed");

    a_holding_needs_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        long_active_reg |-> debounced_state_reg && long_reported_reg)
        else $error("long hold active while released or unreported");

    a_stalled_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_now_reg))
        else $error("pending request lost during stall");

endmodule
